// ===== hdl/sss_pkg.sv =====
// Shared constants, tables and types of the shoot silhouette shading pipeline.
`timescale 1ns / 1ps
`default_nettype none
package sss_pkg;

  // Iteration count of the CORDIC and of the exp series
  localparam int unsigned APPROX_STEPS = 16;

  // Field widths
  localparam int unsigned ANGLE_W = 15;
  localparam int unsigned FIELD_W = 16;
  localparam int unsigned KQ_W    = 14;
  localparam int unsigned P_W     = 32;
  localparam int unsigned KP_W    = 46;
  localparam int unsigned TRIG_W  = 17;
  localparam int unsigned CW      = 34;
  localparam int unsigned SACU_W  = 35;
  localparam int unsigned SAC_W   = 36;
  localparam int unsigned X_W     = 30;
  localparam int unsigned OM_W    = 25;
  localparam int unsigned NUM_W   = 60;
  localparam int unsigned SHADE_W = 16;
  localparam int unsigned OUTC_W  = 2;

  // Stage counts
  localparam int unsigned CORDIC_LAT = APPROX_STEPS + 2;
  localparam int unsigned EXP_LAT    = 9 + 3 * APPROX_STEPS;
  localparam int unsigned DIV2_STEPS = SHADE_W;

  // Fixed-point constants
  localparam logic signed [CW-1:0] HALF_PI_Q30 = 34'sd1686629713;
  localparam logic signed [CW-1:0] PI_Q30      = 34'sd3373259426;
  localparam logic signed [CW-1:0] GAIN_Q30    = 34'sd652032874;
  localparam logic [17:0]          PI_Q16      = 18'd205887;
  localparam logic [23:0]          LN2_Q24     = 24'd11629080;
  localparam logic [30:0]          ONE_Q30     = 31'h4000_0000;

  // Inclination steps: upper angle limit and extinction coefficient
  localparam int unsigned K_STEPS = 9;
  localparam logic [ANGLE_W-1:0] INCL_LIMIT [K_STEPS] = '{
    15'd2830, 15'd5690, 15'd8550, 15'd11409, 15'd14269,
    15'd17128, 15'd19988, 15'd22847, 15'd25735
  };
  localparam logic [KQ_W-1:0] K_Q16 [K_STEPS] = '{
    14'd15073, 14'd14090, 14'd13107, 14'd12452, 14'd11796,
    14'd11272, 14'd11010, 14'd11141, 14'd12059
  };

  typedef enum logic [OUTC_W-1:0] {
    OUT_NORMAL       = 2'd0,
    OUT_ZERO_FOLIAGE = 2'd1,
    OUT_ZERO_AREA    = 2'd2
  } outcome_e;

  // First step whose limit is not exceeded; zero above the last limit
  function automatic logic [KQ_W-1:0] kq_lookup(input logic [ANGLE_W-1:0] ang);
    logic [KQ_W-1:0] k;
    logic            found;
    k     = '0;
    found = 1'b0;
    for (int i = 0; i < K_STEPS; i++) begin
      if (!found && ang <= INCL_LIMIT[i]) begin
        k     = K_Q16[i];
        found = 1'b1;
      end
    end
    return k;
  endfunction

  // Truncated Q30 arctangent of 2^-i
  function automatic logic signed [CW-1:0] atan_q30(input int unsigned i);
    logic signed [CW-1:0] a;
    unique case (i)
      0:  a = 34'sh3243F6A8;
      1:  a = 34'sh1DAC6705;
      2:  a = 34'sh0FADBAFC;
      3:  a = 34'sh07F56EA6;
      4:  a = 34'sh03FEAB76;
      5:  a = 34'sh01FFD55B;
      6:  a = 34'sh00FFFAAA;
      7:  a = 34'sh007FFF55;
      8:  a = 34'sh003FFFEA;
      9:  a = 34'sh001FFFFD;
      10: a = 34'sh000FFFFF;
      11: a = 34'sh0007FFFF;
      12: a = 34'sh0003FFFF;
      13: a = 34'sh0001FFFF;
      14: a = 34'sh0000FFFF;
      15: a = 34'sh00007FFF;
      16: a = 34'sh00003FFF;
      17: a = 34'sh00001FFF;
      18: a = 34'sh00000FFF;
      19: a = 34'sh000007FF;
      20: a = 34'sh000003FF;
      21: a = 34'sh000001FF;
      22: a = 34'sh000000FF;
      23: a = 34'sh0000007F;
      default: a = '0;
    endcase
    return a;
  endfunction

endpackage
`default_nettype wire

// ===== hdl/sss_cordic.sv =====
// Pipelined rotation-mode CORDIC giving |cos|, sin and the cos sign in Q16.
`timescale 1ns / 1ps
`default_nettype none
module sss_cordic import sss_pkg::*; (
  input  logic               clk_i,
  input  logic               en_i,
  input  logic [ANGLE_W-1:0] angle_i,
  output logic [TRIG_W-1:0]  cos_mag_o,
  output logic [TRIG_W-1:0]  sin_o,
  output logic               cos_neg_o
);

  typedef struct packed {
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic signed [CW-1:0] z;
    logic                 flip;
  } cst_t;

  cst_t st_q [APPROX_STEPS+1];

  logic signed [CW-1:0] z0;
  logic                 flip0;

  // Q16 rounding with clamp to [0, 1]
  function automatic logic [TRIG_W-1:0] to_q16(input logic signed [CW-1:0] v);
    logic signed [CW:0] t;
    logic [TRIG_W-1:0]  r;
    t = ($signed({v[CW-1], v}) + 35'sd8192) >>> 14;
    if (t < 0) begin
      r = '0;
    end else if (t > 35'sd65536) begin
      r = 17'd65536;
    end else begin
      r = t[TRIG_W-1:0];
    end
    return r;
  endfunction

  // Reflect angles above pi/2
  assign z0    = $signed({3'b000, angle_i, 16'h0000});
  assign flip0 = z0 > HALF_PI_Q30;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      st_q[0].x    <= GAIN_Q30;
      st_q[0].y    <= '0;
      st_q[0].z    <= flip0 ? PI_Q30 - z0 : z0;
      st_q[0].flip <= flip0;
    end
  end

  // One micro-rotation per stage
  for (genvar i = 0; i < APPROX_STEPS; i++) begin : g_iter
    logic signed [CW-1:0] dx, dy;
    assign dx = st_q[i].y >>> i;
    assign dy = st_q[i].x >>> i;
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        st_q[i+1].flip <= st_q[i].flip;
        if (st_q[i].z >= 0) begin
          st_q[i+1].x <= st_q[i].x - dx;
          st_q[i+1].y <= st_q[i].y + dy;
          st_q[i+1].z <= st_q[i].z - atan_q30(i);
        end else begin
          st_q[i+1].x <= st_q[i].x + dx;
          st_q[i+1].y <= st_q[i].y - dy;
          st_q[i+1].z <= st_q[i].z + atan_q30(i);
        end
      end
    end
  end

  // Round to Q16
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      cos_mag_o <= to_q16(st_q[APPROX_STEPS].x);
      sin_o     <= to_q16(st_q[APPROX_STEPS].y);
      cos_neg_o <= st_q[APPROX_STEPS].flip;
    end
  end

endmodule
`default_nettype wire

// ===== hdl/sss_exp.sv =====
// Pipelined 1 - exp(-x) evaluator: ln2 range reduction and a Taylor series.
`timescale 1ns / 1ps
`default_nettype none
module sss_exp import sss_pkg::*; (
  input  logic            clk_i,
  input  logic            en_i,
  input  logic [X_W-1:0]  x_i,
  output logic [OM_W-1:0] om_o
);

  localparam int unsigned N_W = 7;
  localparam int unsigned TAY = 3 * APPROX_STEPS;

  typedef struct packed {
    logic [X_W-1:0] rem;
    logic [N_W-1:0] n;
  } nst_t;

  typedef struct packed {
    logic [30:0]        term;
    logic [54:0]        prod;
    logic [30:0]        v;
    logic [63:0]        mq;
    logic [23:0]        f;
    logic [N_W-1:0]     n;
    logic signed [32:0] sum;
  } tay_t;

  nst_t nst_q [N_W+1];
  tay_t tay_q [TAY];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      nst_q[0].rem <= x_i;
      nst_q[0].n   <= '0;
    end
  end

  // x = n*ln2 + f, one quotient bit per stage
  for (genvar j = 0; j < N_W; j++) begin : g_red
    localparam int unsigned SH = N_W - 1 - j;
    localparam logic [X_W-1:0] LIM = X_W'({6'b0, LN2_Q24} << SH);
    logic ge;
    assign ge = nst_q[j].rem >= LIM;
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        nst_q[j+1].rem <= ge ? nst_q[j].rem - LIM : nst_q[j].rem;
        nst_q[j+1].n   <= nst_q[j].n | (N_W'(ge) << SH);
      end
    end
  end

  // Series terms: multiply, reciprocal multiply, correction
  for (genvar k = 1; k <= APPROX_STEPS; k++) begin : g_term
    localparam int unsigned B = 3 * (k - 1);
    localparam logic [32:0] RECIP = 33'(64'd4294967296 / k);
    localparam logic [35:0] KC = 36'(k);
    logic [30:0]        term_in;
    logic [23:0]        f_in;
    logic [N_W-1:0]     n_in;
    logic signed [32:0] sum_in;
    logic [30:0]        q0;
    logic [35:0]        rmd;
    tay_t               mul_d, rcp_d, cor_d;

    if (k == 1) begin : g_first
      assign term_in = ONE_Q30;
      assign f_in    = nst_q[N_W].rem[23:0];
      assign n_in    = nst_q[N_W].n;
      assign sum_in  = $signed({2'b00, ONE_Q30});
    end else begin : g_next
      assign term_in = tay_q[B-1].term;
      assign f_in    = tay_q[B-1].f;
      assign n_in    = tay_q[B-1].n;
      // previous term k-1 is subtracted when k-1 is odd
      assign sum_in  = ((k - 1) % 2 == 1)
                     ? tay_q[B-1].sum - $signed({2'b00, tay_q[B-1].term})
                     : tay_q[B-1].sum + $signed({2'b00, tay_q[B-1].term});
    end

    assign q0  = tay_q[B+1].mq[62:32];
    assign rmd = {5'b0, tay_q[B+1].v} - {5'b0, q0} * KC;

    always_comb begin
      mul_d      = '0;
      mul_d.prod = {24'b0, term_in} * {31'b0, f_in};
      mul_d.f    = f_in;
      mul_d.n    = n_in;
      mul_d.sum  = sum_in;

      rcp_d      = tay_q[B];
      rcp_d.v    = tay_q[B].prod[54:24];
      rcp_d.mq   = {33'b0, tay_q[B].prod[54:24]} * {31'b0, RECIP};

      cor_d      = tay_q[B+1];
      cor_d.term = (rmd >= KC) ? q0 + 31'd1 : q0;
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        tay_q[B]   <= mul_d;
        tay_q[B+1] <= rcp_d;
        tay_q[B+2] <= cor_d;
      end
    end
  end

  // Last term, clamp, scale by 2^-n, form 1 - e in Q24
  logic signed [32:0] sum_f;
  logic [30:0]        clamp;
  logic [30:0]        e;

  assign sum_f = (APPROX_STEPS % 2 == 1)
               ? tay_q[TAY-1].sum - $signed({2'b00, tay_q[TAY-1].term})
               : tay_q[TAY-1].sum + $signed({2'b00, tay_q[TAY-1].term});

  always_comb begin
    if (sum_f < 0) begin
      clamp = '0;
    end else if (sum_f > $signed({2'b00, ONE_Q30})) begin
      clamp = ONE_Q30;
    end else begin
      clamp = sum_f[30:0];
    end
    e = (tay_q[TAY-1].n >= 7'd31) ? '0 : clamp >> tay_q[TAY-1].n;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      om_o <= OM_W'((ONE_Q30 - e) >> 6);
    end
  end

endmodule
`default_nettype wire

// ===== hdl/shoot_silhouette_shading.sv =====
// Top level of the shoot silhouette shading pipeline.
//
// Input channel: in_valid_i/in_ready_o with angle, specific leaf area,
// foliage mass, shoot radius and length. Output channel:
// out_valid_o/out_ready_i with shading ratio, extinction coefficient and
// outcome code. Every input transfer gives exactly one output transfer.
//
// Throughput: one item per cycle while the receiver does not stall. The
// latency is set by the CORDIC stages, the 30-bit long division for
// the exponent argument, the exp series (three stages per term) and
// the 16-bit long division of the final ratio.
//
// Reset clears the valid bits of all stages; the pipeline then holds no
// item. When the receiver stalls with a result waiting, the whole pipeline
// holds and in_ready_o falls; nothing is dropped or repeated, and
// the pipeline moves again in the cycle out_ready_i returns.
`timescale 1ns / 1ps
`default_nettype none
module shoot_silhouette_shading import sss_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [ANGLE_W-1:0] angle_i,
  input  logic [FIELD_W-1:0] leaf_area_per_mass_i,
  input  logic [FIELD_W-1:0] foliage_mass_i,
  input  logic [FIELD_W-1:0] shoot_radius_i,
  input  logic [FIELD_W-1:0] shoot_length_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [SHADE_W-1:0] shading_ratio_o,
  output logic [KQ_W-1:0]    extinction_coeff_o,
  output logic [OUTC_W-1:0]  outcome_o
);

  typedef struct packed {
    logic               valid;
    logic [ANGLE_W-1:0] angle;
    logic [KQ_W-1:0]    kq;
    logic [P_W-1:0]     p;
    logic [FIELD_W-1:0] len;
    logic [FIELD_W-1:0] rad;
  } in_t;

  typedef struct packed {
    logic             valid;
    logic [KQ_W-1:0]  kq;
    logic [P_W-1:0]   p;
    logic [KP_W-1:0]  kp;
    logic [31:0]      lr;
    logic [31:0]      rr;
    logic [TRIG_W-1:0] cmag;
    logic [TRIG_W-1:0] sinv;
    logic [48:0]      a;
    logic [48:0]      b;
    logic [33:0]      t1;
    logic [49:0]      t2m;
    logic [SAC_W-1:0] sac;
    logic             cneg;
  } area_t;

  typedef struct packed {
    logic              valid;
    logic [KQ_W-1:0]   kq;
    logic [P_W-1:0]    p;
    logic [SACU_W-1:0] sac_u;
    outcome_e          outcome;
    logic              zero;
  } side_t;

  typedef struct packed {
    side_t             sd;
    logic [SACU_W-1:0] rem;
    logic [X_W-1:0]    bits;
    logic [X_W-1:0]    q;
    logic              ovf;
  } d1_t;

  typedef struct packed {
    side_t              sd;
    logic [P_W-1:0]     rem;
    logic [SHADE_W-1:0] bits;
    logic [SHADE_W-1:0] q;
    logic               ovf;
  } d2_t;

  typedef struct packed {
    logic               valid;
    logic [SHADE_W-1:0] shade;
    logic [KQ_W-1:0]    kq;
    outcome_e           outcome;
  } out_t;

  logic  en;
  in_t   a_q;
  in_t   dl1_q [CORDIC_LAT];
  area_t b1_q, b2_q, b3_q, b4_q;
  area_t b1_d, b2_d, b3_d, b4_d;
  d1_t   d1_q [X_W+1];
  side_t dl2_q [EXP_LAT];
  side_t m_sd_q;
  logic [NUM_W-1:0] m_num_q;
  d2_t   d2_q [DIV2_STEPS+1];
  out_t  o_q;

  logic [TRIG_W-1:0] cos_mag, sin_v;
  logic              cos_neg;
  logic [X_W-1:0]    x_arg;
  logic [OM_W-1:0]   om;

  // Global advance: move unless a result waits on a stalled receiver
  assign en         = !o_q.valid || out_ready_i;
  assign in_ready_o = en;

  // Input stage: K lookup and foliage product
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_q <= '0;
    end else if (en) begin
      a_q.valid <= in_valid_i;
      a_q.angle <= angle_i;
      a_q.kq    <= kq_lookup(angle_i);
      a_q.p     <= {16'b0, leaf_area_per_mass_i} * {16'b0, foliage_mass_i};
      a_q.len   <= shoot_length_i;
      a_q.rad   <= shoot_radius_i;
    end
  end

  sss_cordic u_cordic (
    .clk_i     (clk_i),
    .en_i      (en),
    .angle_i   (a_q.angle),
    .cos_mag_o (cos_mag),
    .sin_o     (sin_v),
    .cos_neg_o (cos_neg)
  );

  // Side data alongside the CORDIC
  for (genvar j = 0; j < CORDIC_LAT; j++) begin : g_dl1
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        dl1_q[j] <= '0;
      end else if (en) begin
        dl1_q[j] <= (j == 0) ? a_q : dl1_q[(j == 0) ? 0 : j - 1];
      end
    end
  end

  // Silhouette area: products, scaling, sum
  always_comb begin
    b1_d       = '0;
    b1_d.valid = dl1_q[CORDIC_LAT-1].valid;
    b1_d.kq    = dl1_q[CORDIC_LAT-1].kq;
    b1_d.p     = dl1_q[CORDIC_LAT-1].p;
    b1_d.kp    = {32'b0, dl1_q[CORDIC_LAT-1].kq} * {14'b0, dl1_q[CORDIC_LAT-1].p};
    b1_d.lr    = {16'b0, dl1_q[CORDIC_LAT-1].len} * {16'b0, dl1_q[CORDIC_LAT-1].rad};
    b1_d.rr    = {16'b0, dl1_q[CORDIC_LAT-1].rad} * {16'b0, dl1_q[CORDIC_LAT-1].rad};
    b1_d.cmag  = cos_mag;
    b1_d.sinv  = sin_v;
    b1_d.cneg  = cos_neg;

    b2_d       = b1_q;
    b2_d.a     = {17'b0, b1_q.lr} * {32'b0, b1_q.cmag};
    b2_d.b     = {17'b0, b1_q.rr} * {32'b0, b1_q.sinv};

    b3_d       = b2_q;
    b3_d.t1    = b2_q.a[48:15];
    b3_d.t2m   = {18'b0, b2_q.b[47:16]} * {32'b0, PI_Q16};

    b4_d       = b3_q;
    b4_d.sac   = b3_q.cneg ? {2'b00, b3_q.t2m[49:16]} - {2'b00, b3_q.t1}
                           : {2'b00, b3_q.t2m[49:16]} + {2'b00, b3_q.t1};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b1_q <= '0;
      b2_q <= '0;
      b3_q <= '0;
      b4_q <= '0;
    end else if (en) begin
      b1_q <= b1_d;
      b2_q <= b2_d;
      b3_q <= b3_d;
      b4_q <= b4_d;
    end
  end

  // Special cases and divider setup for x = K*P*2^16 / SAc
  logic     pz, sz;
  outcome_e oc;
  assign pz = b4_q.p == '0;
  assign sz = b4_q.sac == '0;

  always_comb begin
    priority if (pz) begin
      oc = OUT_ZERO_FOLIAGE;
    end else if (sz) begin
      oc = OUT_ZERO_AREA;
    end else begin
      oc = OUT_NORMAL;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      d1_q[0] <= '0;
    end else if (en) begin
      d1_q[0].sd.valid   <= b4_q.valid;
      d1_q[0].sd.kq      <= b4_q.kq;
      d1_q[0].sd.p       <= b4_q.p;
      d1_q[0].sd.sac_u   <= b4_q.sac[SACU_W-1:0];
      d1_q[0].sd.outcome <= oc;
      d1_q[0].sd.zero    <= pz || sz || b4_q.sac[SAC_W-1];
      d1_q[0].ovf        <= {3'b000, b4_q.kp} >= {b4_q.sac[SACU_W-1:0], 14'b0};
      d1_q[0].rem        <= {3'b000, b4_q.kp[45:14]};
      d1_q[0].bits       <= {b4_q.kp[13:0], 16'b0};
      d1_q[0].q          <= '0;
    end
  end

  // Restoring division, one quotient bit per stage
  for (genvar j = 0; j < X_W; j++) begin : g_div1
    logic [SACU_W:0] trial;
    logic            ge;
    assign trial = {d1_q[j].rem, d1_q[j].bits[X_W-1]};
    assign ge    = trial >= {1'b0, d1_q[j].sd.sac_u};
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        d1_q[j+1] <= '0;
      end else if (en) begin
        d1_q[j+1].sd   <= d1_q[j].sd;
        d1_q[j+1].ovf  <= d1_q[j].ovf;
        d1_q[j+1].rem  <= ge ? SACU_W'(trial - {1'b0, d1_q[j].sd.sac_u})
                             : trial[SACU_W-1:0];
        d1_q[j+1].bits <= {d1_q[j].bits[X_W-2:0], 1'b0};
        d1_q[j+1].q    <= {d1_q[j].q[X_W-2:0], ge};
      end
    end
  end

  // A quotient too large for 30 bits drives exp(-x) to zero either way
  assign x_arg = d1_q[X_W].ovf ? '1 : d1_q[X_W].q;

  sss_exp u_exp (
    .clk_i (clk_i),
    .en_i  (en),
    .x_i   (x_arg),
    .om_o  (om)
  );

  // Side data alongside the exp unit
  for (genvar j = 0; j < EXP_LAT; j++) begin : g_dl2
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        dl2_q[j] <= '0;
      end else if (en) begin
        dl2_q[j] <= (j == 0) ? d1_q[X_W].sd : dl2_q[(j == 0) ? 0 : j - 1];
      end
    end
  end

  // Numerator SAc * (1 - e)
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_sd_q <= '0;
    end else if (en) begin
      m_sd_q <= dl2_q[EXP_LAT-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      m_num_q <= {25'b0, dl2_q[EXP_LAT-1].sac_u} * {35'b0, om};
    end
  end

  // Divider setup for (num >> 16) / P with saturation
  logic [43:0] np;
  assign np = m_num_q[NUM_W-1:16];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      d2_q[0] <= '0;
    end else if (en) begin
      d2_q[0].sd   <= m_sd_q;
      d2_q[0].ovf  <= {4'b0, np} >= {m_sd_q.p, 16'b0};
      d2_q[0].rem  <= {4'b0, np[43:16]};
      d2_q[0].bits <= np[15:0];
      d2_q[0].q    <= '0;
    end
  end

  for (genvar j = 0; j < DIV2_STEPS; j++) begin : g_div2
    logic [P_W:0] trial;
    logic         ge;
    assign trial = {d2_q[j].rem, d2_q[j].bits[SHADE_W-1]};
    assign ge    = trial >= {1'b0, d2_q[j].sd.p};
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        d2_q[j+1] <= '0;
      end else if (en) begin
        d2_q[j+1].sd   <= d2_q[j].sd;
        d2_q[j+1].ovf  <= d2_q[j].ovf;
        d2_q[j+1].rem  <= ge ? P_W'(trial - {1'b0, d2_q[j].sd.p}) : trial[P_W-1:0];
        d2_q[j+1].bits <= {d2_q[j].bits[SHADE_W-2:0], 1'b0};
        d2_q[j+1].q    <= {d2_q[j].q[SHADE_W-2:0], ge};
      end
    end
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      o_q <= '0;
    end else if (en) begin
      o_q.valid   <= d2_q[DIV2_STEPS].sd.valid;
      o_q.kq      <= d2_q[DIV2_STEPS].sd.kq;
      o_q.outcome <= d2_q[DIV2_STEPS].sd.outcome;
      if (d2_q[DIV2_STEPS].sd.zero) begin
        o_q.shade <= '0;
      end else if (d2_q[DIV2_STEPS].ovf) begin
        o_q.shade <= '1;
      end else begin
        o_q.shade <= d2_q[DIV2_STEPS].q;
      end
    end
  end

  assign out_valid_o        = o_q.valid;
  assign shading_ratio_o    = o_q.shade;
  assign extinction_coeff_o = o_q.kq;
  assign outcome_o          = o_q.outcome;

  // A special outcome always carries a zero ratio
  a_special_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (outcome_o != OUT_NORMAL) |-> shading_ratio_o == '0)
    else $error("special outcome with nonzero shading ratio");

  // No extinction means no shading
  a_k_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (extinction_coeff_o == '0) |-> shading_ratio_o == '0)
    else $error("zero coefficient with nonzero shading ratio");

  // A stalled result keeps the pipeline frozen
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(extinction_coeff_o))
    else $error("pipeline moved during stall");

endmodule
`default_nettype wire
